FILE: rtl/work_split_start_digits_macros.svh
// Assertion macros shared by the work split RTL.
`ifndef WORK_SPLIT_START_DIGITS_MACROS_SVH
`define WORK_SPLIT_START_DIGITS_MACROS_SVH

// Plain property, clocked on clk_i and off during reset.
`define WSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication, clocked on clk_i and off during reset.
`define WSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/wsd_pkg.sv
// Package: widths, register indexes and divider handshake types for the work split block.
`default_nettype none

package wsd_pkg;

  localparam int MAX_LOOPS  = 8;
  localparam int COUNT_BITS = 48;

  localparam int BASE_W     = 16;
  localparam int LOOP_W     = 4;
  localparam int WORKERS_W  = 11;
  localparam int ID_W       = 10;
  localparam int POS_W      = 4;
  localparam int VALUE_W    = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int START_W    = COUNT_BITS + ID_W;
  localparam int DIV_W      = START_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int LVL_W      = $clog2(MAX_LOOPS + 1);
  localparam int PROD_W     = COUNT_BITS + BASE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_N       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT = 2'd2;

  localparam logic [BASE_W-1:0]    BASE_N_RST       = 16'd2;
  localparam logic [LOOP_W-1:0]    LOOP_COUNT_RST   = 4'd1;
  localparam logic [WORKERS_W-1:0] WORKER_COUNT_RST = 11'd1;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [BASE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [BASE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/work_split_start_digits.sv
// Top level: work partition sequencer with start-digit output.
// Steps: build the total over L levels, L the effective loop depth (0..8), divide it
//   by the workers, form start and count, then send a digit per level and the count word.
//   The 58-step radix-2 divider serves the share and each digit when the base is nonzero.
// Throughput: one query at a time; busy stays high until the count word is out.
// Output: words on out_valid_o, never stalled. Reset (rst_ni low,
//   async): sequencer idle, no word pending, registers at base 2, depth 1, 1 worker.
`default_nettype none
`include "work_split_start_digits_macros.svh"

module work_split_start_digits (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [wsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // query
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [wsd_pkg::ID_W-1:0]        worker_id_i,
  // result words
  output logic                                 out_valid_o,
  output logic      [wsd_pkg::POS_W-1:0]       position_o,
  output logic      [wsd_pkg::VALUE_W-1:0]     value_o,
  output logic                                 is_count_o,
  output logic                                 overflow_o,
  output logic                                 last_item_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0; // wait for a query
  localparam logic [2:0] S_TOT  = 3'd1; // multiply total by base, or launch the share divide
  localparam logic [2:0] S_CHK  = 3'd2; // check the product against the count width
  localparam logic [2:0] S_WSH  = 3'd3; // wait for total / workers
  localparam logic [2:0] S_PROD = 3'd4; // share * id into the multiplier
  localparam logic [2:0] S_ADD  = 3'd5; // form start and count
  localparam logic [2:0] S_DIG  = 3'd6; // launch a digit divide or send the count word
  localparam logic [2:0] S_WDIG = 3'd7; // wait for one digit

  // Configuration registers.
  logic [wsd_pkg::BASE_W-1:0]    base_q;
  logic [wsd_pkg::LOOP_W-1:0]    loops_q;
  logic [wsd_pkg::WORKERS_W-1:0] workers_q;

  // Sequencer state and working registers.
  logic [2:0]                     state_q, state_d;
  logic [wsd_pkg::LVL_W-1:0]      lvl_q, lvl_d;
  logic                           ovf_q, ovf_d;
  logic [wsd_pkg::ID_W-1:0]       id_q, id_d;
  logic [wsd_pkg::COUNT_BITS-1:0] total_q, total_d;
  logic [wsd_pkg::COUNT_BITS-1:0] share_q, share_d;
  logic [wsd_pkg::WORKERS_W-1:0]  wrem_q, wrem_d;
  logic [wsd_pkg::START_W-1:0]    start_q, start_d;
  logic [wsd_pkg::COUNT_BITS-1:0] count_q, count_d;

  // Output word registers.
  logic                           oval_q, oval_d;
  logic [wsd_pkg::POS_W-1:0]      opos_q, opos_d;
  logic [wsd_pkg::VALUE_W-1:0]    ovalue_q, ovalue_d;
  logic                           ocnt_q, ocnt_d;
  logic                           oovf_q, oovf_d;
  logic                           olast_q, olast_d;

  // Shared units.
  wsd_pkg::div_req_t              div_req;
  wsd_pkg::div_rsp_t              div_rsp;
  logic [wsd_pkg::COUNT_BITS-1:0] mul_a;
  logic [wsd_pkg::BASE_W-1:0]     mul_b;
  logic [wsd_pkg::PROD_W-1:0]     prod;

  // Effective configuration: clamp the depth, treat zero workers as one.
  logic [wsd_pkg::LVL_W-1:0]      lvl_eff;
  logic [wsd_pkg::WORKERS_W-1:0]  workers_eff;
  logic                           id_lt_rem;
  logic [wsd_pkg::WORKERS_W-1:0]  id_ext;
  logic [wsd_pkg::WORKERS_W-1:0]  extra;

  assign lvl_eff = (loops_q > wsd_pkg::LOOP_W'(wsd_pkg::MAX_LOOPS))
                 ? wsd_pkg::LVL_W'(wsd_pkg::MAX_LOOPS)
                 : wsd_pkg::LVL_W'(loops_q);
  assign workers_eff = (workers_q == '0) ? wsd_pkg::WORKERS_W'(1) : workers_q;

  assign id_ext    = wsd_pkg::WORKERS_W'(id_q);
  assign id_lt_rem = id_ext < wrem_q;
  assign extra     = id_lt_rem ? id_ext : wrem_q;

  // The multiplier builds the total except while forming share * id.
  assign mul_a = (state_q == S_PROD) ? share_q : total_q;
  assign mul_b = (state_q == S_PROD) ? wsd_pkg::BASE_W'(id_q) : base_q;

  wsd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  wsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    ovf_d    = ovf_q;
    id_d     = id_q;
    total_d  = total_q;
    share_d  = share_q;
    wrem_d   = wrem_q;
    start_d  = start_q;
    count_d  = count_q;

    oval_d   = 1'b0;
    opos_d   = opos_q;
    ovalue_d = ovalue_q;
    ocnt_d   = ocnt_q;
    oovf_d   = oovf_q;
    olast_d  = olast_q;

    div_req.start = 1'b0;
    div_req.num   = start_q;
    div_req.den   = base_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          id_d    = worker_id_i;
          total_d = wsd_pkg::COUNT_BITS'(1);
          lvl_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_TOT;
        end
      end
      S_TOT: begin
        if (lvl_q == lvl_eff) begin
          // total is zero after an overflow, so every share is zero too
          div_req.start = 1'b1;
          div_req.num   = wsd_pkg::DIV_W'(total_q);
          div_req.den   = wsd_pkg::BASE_W'(workers_eff);
          state_d       = S_WSH;
        end else if (ovf_q) begin
          lvl_d = lvl_q + 1'b1;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (|prod[wsd_pkg::PROD_W-1:wsd_pkg::COUNT_BITS]) begin
          ovf_d   = 1'b1;
          total_d = '0;
        end else begin
          total_d = prod[wsd_pkg::COUNT_BITS-1:0];
        end
        lvl_d   = lvl_q + 1'b1;
        state_d = S_TOT;
      end
      S_WSH: begin
        if (div_rsp.done) begin
          share_d = div_rsp.quot[wsd_pkg::COUNT_BITS-1:0];
          wrem_d  = div_rsp.rem[wsd_pkg::WORKERS_W-1:0];
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        start_d = prod[wsd_pkg::START_W-1:0] + wsd_pkg::START_W'(extra);
        count_d = share_q + wsd_pkg::COUNT_BITS'(id_lt_rem);
        lvl_d   = '0;
        state_d = S_DIG;
      end
      S_DIG: begin
        if (lvl_q == lvl_eff) begin
          // send the count word, marked last
          oval_d   = 1'b1;
          opos_d   = wsd_pkg::POS_W'(lvl_q);
          ovalue_d = ovf_q ? '0 : wsd_pkg::VALUE_W'(count_q);
          ocnt_d   = 1'b1;
          oovf_d   = ovf_q;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end else if (base_q == '0) begin
          // zero base: digit is zero, start left as it is
          oval_d   = 1'b1;
          opos_d   = wsd_pkg::POS_W'(lvl_q);
          ovalue_d = '0;
          ocnt_d   = 1'b0;
          oovf_d   = ovf_q;
          olast_d  = 1'b0;
          lvl_d    = lvl_q + 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_WDIG;
        end
      end
      S_WDIG: begin
        if (div_rsp.done) begin
          oval_d   = 1'b1;
          opos_d   = wsd_pkg::POS_W'(lvl_q);
          ovalue_d = ovf_q ? '0 : wsd_pkg::VALUE_W'(div_rsp.rem);
          ocnt_d   = 1'b0;
          oovf_d   = ovf_q;
          olast_d  = 1'b0;
          start_d  = div_rsp.quot;
          lvl_d    = lvl_q + 1'b1;
          state_d  = S_DIG;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      lvl_q     <= '0;
      ovf_q     <= 1'b0;
      oval_q    <= 1'b0;
      base_q    <= wsd_pkg::BASE_N_RST;
      loops_q   <= wsd_pkg::LOOP_COUNT_RST;
      workers_q <= wsd_pkg::WORKER_COUNT_RST;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      ovf_q   <= ovf_d;
      oval_q  <= oval_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wsd_pkg::CFG_BASE_N:       base_q    <= cfg_data_i;
          wsd_pkg::CFG_LOOP_COUNT:   loops_q   <= cfg_data_i[wsd_pkg::LOOP_W-1:0];
          wsd_pkg::CFG_WORKER_COUNT: workers_q <= cfg_data_i[wsd_pkg::WORKERS_W-1:0];
          default: begin
            // drop writes to unused indexes
          end
        endcase
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    total_q  <= total_d;
    share_q  <= share_d;
    wrem_q   <= wrem_d;
    start_q  <= start_d;
    count_q  <= count_d;
    opos_q   <= opos_d;
    ovalue_q <= ovalue_d;
    ocnt_q   <= ocnt_d;
    oovf_q   <= oovf_d;
    olast_q  <= olast_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign out_valid_o = oval_q;
  assign position_o  = opos_q;
  assign value_o     = ovalue_q;
  assign is_count_o  = ocnt_q;
  assign overflow_o  = oovf_q;
  assign last_item_o = olast_q;

  `WSD_ASSERT_IMP(a_last_is_count, out_valid_o, last_item_o == is_count_o, "last word is not the count word")
  `WSD_ASSERT_IMP(a_ovf_zero_value, out_valid_o && overflow_o, value_o == '0, "overflowed word carries a value")
  `WSD_ASSERT_IMP(a_count_position, out_valid_o && is_count_o, position_o == wsd_pkg::POS_W'(lvl_eff), "count word at wrong position")
  `WSD_ASSERT_IMP(a_idle_after_last, $fell(busy), out_valid_o && last_item_o, "query ended without a last word")

endmodule

`default_nettype wire

FILE: rtl/wsd_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
`include "work_split_start_digits_macros.svh"

module wsd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wsd_pkg::div_req_t req_i,
  output wsd_pkg::div_rsp_t      rsp_o
);

  logic                             run_q;
  logic                             done_q;
  logic [wsd_pkg::DIV_CNT_W-1:0]    cnt_q;
  logic [wsd_pkg::DIV_W-1:0]        quot_q;
  logic [wsd_pkg::BASE_W-1:0]       rem_q;
  logic [wsd_pkg::BASE_W-1:0]       den_q;
  logic [wsd_pkg::BASE_W:0]         trial;
  logic [wsd_pkg::BASE_W+1:0]       diff;
  logic                             ge;

  // Shift in the next dividend bit and try a subtraction.
  assign trial = {rem_q, quot_q[wsd_pkg::DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[wsd_pkg::BASE_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= wsd_pkg::DIV_CNT_W'(wsd_pkg::DIV_W);
    end else if (run_q) begin
      cnt_q  <= cnt_q - 1'b1;
      run_q  <= (cnt_q != wsd_pkg::DIV_CNT_W'(1));
      done_q <= (cnt_q == wsd_pkg::DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (run_q) begin
      quot_q <= {quot_q[wsd_pkg::DIV_W-2:0], ge};
      rem_q  <= ge ? diff[wsd_pkg::BASE_W-1:0] : trial[wsd_pkg::BASE_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  `WSD_ASSERT_IMP(a_div_rem_below_den, done_q && (den_q != '0), rem_q < den_q, "divider remainder not below divisor")
  `WSD_ASSERT_IMP(a_div_cnt_live, run_q, cnt_q != '0, "divider running with zero step count")

endmodule

`default_nettype wire

FILE: rtl/wsd_mul.sv
// Registered multiplier shared by the total build-up and the start offset.
`default_nettype none

module wsd_mul (
  input  wire logic                            clk_i,
  input  wire logic [wsd_pkg::COUNT_BITS-1:0]  a_i,
  input  wire logic [wsd_pkg::BASE_W-1:0]      b_i,
  output logic      [wsd_pkg::PROD_W-1:0]      p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= wsd_pkg::PROD_W'(a_i) * wsd_pkg::PROD_W'(b_i);
  end

endmodule

`default_nettype wire
